/* sv/assert_macros.svh */
// Assertion macros shared by the converter RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IGSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IGSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IGSC_ASSERT(label, clk, rst_n, prop, msg)
`define IGSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/igsc_pkg.sv */
// Package for the ideal-gas state converter: defaults, register map, opcodes.
// No dependencies.
`default_nettype none
package igsc_pkg;
	localparam int DEF_WORD_WIDTH = 48;
	localparam int DEF_FRAC_BITS = 16;
	localparam int CFG_W = 41;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_W-1:0] RST_GAS_CONSTANT = 41'd18808832;
	localparam logic [CFG_W-1:0] RST_SPECIFIC_HEAT_CV = 41'd47022080;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAS_CONSTANT = 8'd0,
		CFG_SPECIFIC_HEAT_CV = 8'd1
	} cfg_reg_t;

	typedef enum logic {
		OP_PRIM_TO_CONS = 1'b0,
		OP_CONS_TO_PRIM = 1'b1
	} op_t;
endpackage
`default_nettype wire

/* sv/igsc_if.sv */
// Channel interfaces of the converter: input, result and register write.
// Depends on igsc_pkg.
`default_nettype none
interface igsc_in_if #(parameter int W = igsc_pkg::DEF_WORD_WIDTH);
	logic valid;
	logic ready;
	logic opcode;
	logic signed [W-1:0] in_0;
	logic signed [W-1:0] in_1;
	logic signed [W-1:0] in_2;
	logic signed [W-1:0] in_3;
	logic signed [W-1:0] in_4;
	modport source (output valid, opcode, in_0, in_1, in_2, in_3, in_4, input ready);
	modport sink (input valid, opcode, in_0, in_1, in_2, in_3, in_4, output ready);
endinterface

interface igsc_out_if #(parameter int W = igsc_pkg::DEF_WORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [W-1:0] density;
	logic signed [W-1:0] vel_x;
	logic signed [W-1:0] vel_y;
	logic signed [W-1:0] vel_z;
	logic signed [W-1:0] specific_energy;
	logic signed [W-1:0] temperature;
	logic signed [W-1:0] pressure;
	logic signed [W-1:0] mom_x;
	logic signed [W-1:0] mom_y;
	logic signed [W-1:0] mom_z;
	logic signed [W-1:0] energy_density;
	logic div_fault;
	modport source (output valid, density, vel_x, vel_y, vel_z, specific_energy,
		temperature, pressure, mom_x, mom_y, mom_z, energy_density, div_fault,
		input ready);
	modport sink (input valid, density, vel_x, vel_y, vel_z, specific_energy,
		temperature, pressure, mom_x, mom_y, mom_z, energy_density, div_fault,
		output ready);
endinterface

interface igsc_cfg_if;
	logic valid;
	logic ready;
	logic [igsc_pkg::CFG_IDX_W-1:0] index;
	logic [igsc_pkg::CFG_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/igsc_pipe.sv */
// Delay line with a shared advance enable, used for side data and valid flags.
// No dependencies.
`default_nettype none
module igsc_pipe #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);
	logic [DEPTH-1:0][WIDTH-1:0] stg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= '0;
		end else if (en) begin
			stg_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				stg_q[i] <= stg_q[i-1];
			end
		end
	end

	assign q = stg_q[DEPTH-1];
endmodule
`default_nettype wire

/* sv/igsc_mul.sv */
// Two-stage sign-magnitude fixed-point multiplier, split into half-width products.
// Truncates the fraction toward zero and saturates to the word range.
`default_nettype none
module igsc_mul #(
	parameter int W = 48,
	parameter int F = 16,
	parameter int MW = 48
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [MW:0] a,
	input  wire logic [MW:0] b,
	output logic      [W:0]  p
);
	localparam int HW = (MW + 1) / 2;
	localparam int UW = MW - HW;
	localparam int PW = 2 * MW;
	localparam logic [PW-1:0] LIM_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW-1:0] LIM_N = LIM_P + 1'b1;

	logic              neg_s1;
	logic [2*HW-1:0]   ll_s1;
	logic [HW+UW-1:0]  lh_s1;
	logic [HW+UW-1:0]  hl_s1;
	logic [2*UW-1:0]   hh_s1;
	logic [PW-1:0]     full;
	logic [PW-1:0]     shifted;
	logic [PW-1:0]     lim;
	logic [PW-1:0]     mag;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[MW] ^ b[MW];
			ll_s1 <= a[HW-1:0] * b[HW-1:0];
			lh_s1 <= a[HW-1:0] * b[MW-1:HW];
			hl_s1 <= a[MW-1:HW] * b[HW-1:0];
			hh_s1 <= a[MW-1:HW] * b[MW-1:HW];
		end
	end

	always_comb begin
		full = PW'(ll_s1) + (PW'(lh_s1) << HW) + (PW'(hl_s1) << HW)
			+ (PW'(hh_s1) << (2 * HW));
		shifted = full >> F;
		lim = neg_s1 ? LIM_N : LIM_P;
		mag = (shifted > lim) ? lim : shifted;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= {neg_s1 && (mag != '0), mag[W-1:0]};
		end
	end
endmodule
`default_nettype wire

/* sv/igsc_div_cell.sv */
// One restoring-division cell: develops one quotient bit and hands on to the next.
// No dependencies.
`default_nettype none
module igsc_div_cell #(
	parameter int W = 48,
	parameter int DW = 48,
	parameter int NB = 64
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [NB-1:0] num_i,
	input  wire logic [W-1:0]  quo_i,
	input  wire logic          ovf_i,
	input  wire logic [DW-1:0] den_i,
	input  wire logic          neg_i,
	output logic      [DW-1:0] rem_o,
	output logic      [NB-1:0] num_o,
	output logic      [W-1:0]  quo_o,
	output logic               ovf_o,
	output logic      [DW-1:0] den_o,
	output logic               neg_o
);
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_i, num_i[NB-1]};
		diff = trial - {1'b0, den_i};
		ge = trial >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_o <= num_i << 1;
			quo_o <= {quo_i[W-2:0], ge};
			ovf_o <= ovf_i | quo_i[W-1];
			den_o <= den_i;
			neg_o <= neg_i;
		end
	end
endmodule
`default_nettype wire

/* sv/igsc_div.sv */
// Pipelined fixed-point divider: a chain of W+F division cells and a saturation stage.
// Depends on igsc_div_cell.
`default_nettype none
module igsc_div #(
	parameter int W = 48,
	parameter int F = 16,
	parameter int MW = 48
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [W:0]  num,
	input  wire logic [MW:0] den,
	output logic      [W:0]  q
);
	localparam int NB = W + F;
	localparam logic [W:0] LIM_P = {2'b00, {(W-1){1'b1}}};
	localparam logic [W:0] LIM_N = {2'b01, {(W-1){1'b0}}};

	logic [NB:0][MW-1:0] rem;
	logic [NB:0][NB-1:0] nbits;
	logic [NB:0][W-1:0]  quo;
	logic [NB:0]         ovf;
	logic [NB:0][MW-1:0] dv;
	logic [NB:0]         neg;
	logic [W:0]          lim;
	logic [W:0]          mag;

	assign rem[0] = '0;
	assign nbits[0] = {num[W-1:0], {F{1'b0}}};
	assign quo[0] = '0;
	assign ovf[0] = 1'b0;
	assign dv[0] = den[MW-1:0];
	assign neg[0] = num[W] ^ den[MW];

	for (genvar k = 0; k < NB; k++) begin : g_cell
		igsc_div_cell #(.W(W), .DW(MW), .NB(NB)) u_cell (
			.clk(clk), .en(en),
			.rem_i(rem[k]), .num_i(nbits[k]), .quo_i(quo[k]), .ovf_i(ovf[k]),
			.den_i(dv[k]), .neg_i(neg[k]),
			.rem_o(rem[k+1]), .num_o(nbits[k+1]), .quo_o(quo[k+1]), .ovf_o(ovf[k+1]),
			.den_o(dv[k+1]), .neg_o(neg[k+1])
		);
	end

	always_comb begin
		lim = neg[NB] ? LIM_N : LIM_P;
		mag = (ovf[NB] || ({1'b0, quo[NB]} > lim)) ? lim : {1'b0, quo[NB]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= {neg[NB] && (mag != '0), mag[W-1:0]};
		end
	end
endmodule
`default_nettype wire

/* sv/ideal_gas_state_converter_unit.sv */
// Ideal-gas primitive/conservative converter, top level.
// Accepts one transaction per cycle while no result waits at the output.
// Pipeline depth is set mainly by the two restoring divider chains of WORD_WIDTH+FRAC_BITS cells each.
// The whole pipeline advances together and holds while a result waits at the output.
// Reset clears the valid flags and loads the default gas constant and cv.
`default_nettype none
`include "assert_macros.svh"
module ideal_gas_state_converter_unit #(
	parameter int WORD_WIDTH = igsc_pkg::DEF_WORD_WIDTH,
	parameter int FRAC_BITS = igsc_pkg::DEF_FRAC_BITS
) (
	input wire logic    clk,
	input wire logic    arst_n,
	igsc_in_if.sink     in_ch,
	igsc_out_if.source  out_ch,
	igsc_cfg_if.sink    cfg
);
	import igsc_pkg::*;

	localparam int W = WORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int MW = (W > CFG_W) ? W : CFG_W;
	localparam int SM = W + 1;
	localparam int DL = W + F + 1;
	localparam int LAT = 10 + 2 * DL;
	localparam logic [W:0] LIM_P = {2'b00, {(W-1){1'b1}}};
	localparam logic [W:0] LIM_N = {2'b01, {(W-1){1'b0}}};

	function automatic logic [W:0] from_raw(input logic [W-1:0] r);
		from_raw = {r[W-1], r[W-1] ? (~r + 1'b1) : r};
	endfunction

	function automatic logic [W-1:0] to_raw(input logic [W:0] x);
		to_raw = x[W] ? (~x[W-1:0] + 1'b1) : x[W-1:0];
	endfunction

	function automatic logic [MW:0] ext(input logic [W:0] x);
		ext = {x[W], MW'(x[W-1:0])};
	endfunction

	function automatic logic [W:0] sm_add(input logic [W:0] x, input logic [W:0] y);
		logic [W:0] xm;
		logic [W:0] ym;
		logic [W:0] m;
		logic       n;
		logic [W:0] lim;
		xm = {1'b0, x[W-1:0]};
		ym = {1'b0, y[W-1:0]};
		if (x[W] == y[W]) begin
			m = xm + ym;
			n = x[W];
		end else if (xm >= ym) begin
			m = xm - ym;
			n = x[W];
		end else begin
			m = ym - xm;
			n = y[W];
		end
		lim = n ? LIM_N : LIM_P;
		if (m > lim) begin
			m = lim;
		end
		sm_add = {n && (m != '0), m[W-1:0]};
	endfunction

	logic                 en;
	logic [CFG_W-1:0]     gas_q;
	logic [CFG_W-1:0]     cv_q;

	logic                 v_s1;
	logic                 op_s1;
	logic [4:0][W:0]      a_s1;

	logic [W:0]           rt_s3;
	logic [W:0]           rr_s3;
	logic                 op_s3;
	logic [4:0][W:0]      a_s3;
	logic                 fault_s3;
	logic                 prim_s3;
	logic [W:0]           num0_s3;
	logic [MW:0]          den0_s3;
	logic [3:0][W:0]      q_s4;

	logic                 op_s4;
	logic                 fault_s4;
	logic [4:0][W:0]      a_s4;
	logic [W:0]           rr_s4;
	logic [W:0]           rho_s4;
	logic [2:0][W:0]      vel_s4;
	logic [2:0][W:0]      sq_s6;
	logic [W:0]           cvt_s6;

	logic                 op_s6;
	logic                 fault_s6;
	logic [4:0][W:0]      a_s6;
	logic [W:0]           rr_s6;
	logic [W:0]           rho_s6;
	logic [2:0][W:0]      vel_s6;
	logic [W:0]           et_s6;
	logic [W:0]           hs_s6;

	logic                 op_s7;
	logic                 fault_s7;
	logic [4:0][W:0]      a_s7;
	logic [W:0]           rr_s7;
	logic [W:0]           rho_s7;
	logic [2:0][W:0]      vel_s7;
	logic [W:0]           et_s7;
	logic [W:0]           hs_s7;
	logic [W:0]           cvt_s7;
	logic [W:0]           etn_s7;

	logic                 op_s8;
	logic                 fault_s8;
	logic [4:0][W:0]      a_s8;
	logic [W:0]           rr_s8;
	logic [W:0]           rho_s8;
	logic [2:0][W:0]      vel_s8;
	logic [W:0]           et_s8;
	logic [W:0]           etn_s8;

	logic [W:0]           tq_s9;
	logic                 op_s9;
	logic                 fault_s9;
	logic [4:0][W:0]      a_s9;
	logic [W:0]           rr_s9;
	logic [W:0]           rho_s9;
	logic [2:0][W:0]      vel_s9;
	logic [W:0]           et_s9;
	logic [W:0]           t_s9;
	logic                 prim_s9;
	logic [3:0][W:0]      m_s11;

	logic                 op_s11;
	logic                 fault_s11;
	logic [4:0][W:0]      a_s11;
	logic [W:0]           rho_s11;
	logic [2:0][W:0]      vel_s11;
	logic [W:0]           et_s11;
	logic [W:0]           t_s11;
	logic                 prim_s11;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_q <= RST_GAS_CONSTANT;
			cv_q <= RST_SPECIFIC_HEAT_CV;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_GAS_CONSTANT: gas_q <= cfg.data;
				CFG_SPECIFIC_HEAT_CV: cv_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_ch.opcode;
			a_s1[0] <= from_raw(in_ch.in_0);
			a_s1[1] <= from_raw(in_ch.in_1);
			a_s1[2] <= from_raw(in_ch.in_2);
			a_s1[3] <= from_raw(in_ch.in_3);
			a_s1[4] <= from_raw(in_ch.in_4);
		end
	end

	igsc_pipe #(.WIDTH(1), .DEPTH(LAT - 1)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(v_s1), .q(out_ch.valid)
	);

	// R*T and rho*R
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_rt (
		.clk(clk), .en(en), .a({1'b0, MW'(gas_q)}), .b(ext(a_s1[1])), .p(rt_s3)
	);
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_rr (
		.clk(clk), .en(en), .a(ext(a_s1[0])), .b({1'b0, MW'(gas_q)}), .p(rr_s3)
	);
	igsc_pipe #(.WIDTH(1 + 5 * SM), .DEPTH(2)) u_p1 (
		.clk(clk), .arst_n(arst_n), .en(en), .d({op_s1, a_s1}), .q({op_s3, a_s3})
	);

	// first divider bank
	always_comb begin
		prim_s3 = (op_s3 == OP_PRIM_TO_CONS);
		fault_s3 = prim_s3 ? (rt_s3[W-1:0] == '0)
			: ((a_s3[0][W-1:0] == '0) || (cv_q == '0));
		num0_s3 = prim_s3 ? a_s3[0] : a_s3[1];
		den0_s3 = prim_s3 ? ext(rt_s3) : ext(a_s3[0]);
	end

	igsc_div #(.W(W), .F(F), .MW(MW)) u_div_a0 (
		.clk(clk), .en(en), .num(num0_s3), .den(den0_s3), .q(q_s4[0])
	);
	for (genvar i = 1; i < 4; i++) begin : g_div_a
		igsc_div #(.W(W), .F(F), .MW(MW)) u_div (
			.clk(clk), .en(en), .num(a_s3[i+1]), .den(ext(a_s3[0])), .q(q_s4[i])
		);
	end
	igsc_pipe #(.WIDTH(2 + 6 * SM), .DEPTH(DL)) u_p2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s3, fault_s3, a_s3, rr_s3}), .q({op_s4, fault_s4, a_s4, rr_s4})
	);

	// squares and cv*T
	always_comb begin
		if (op_s4 == OP_PRIM_TO_CONS) begin
			rho_s4 = q_s4[0];
			vel_s4 = {a_s4[4], a_s4[3], a_s4[2]};
		end else begin
			rho_s4 = a_s4[0];
			vel_s4 = {q_s4[2], q_s4[1], q_s4[0]};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_sq
		igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul (
			.clk(clk), .en(en), .a(ext(vel_s4[i])), .b(ext(vel_s4[i])), .p(sq_s6[i])
		);
	end
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_cvt (
		.clk(clk), .en(en), .a({1'b0, MW'(cv_q)}), .b(ext(a_s4[1])), .p(cvt_s6)
	);
	igsc_pipe #(.WIDTH(2 + 11 * SM), .DEPTH(2)) u_p3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s4, fault_s4, a_s4, rr_s4, rho_s4, vel_s4, q_s4[3]}),
		.q({op_s6, fault_s6, a_s6, rr_s6, rho_s6, vel_s6, et_s6})
	);

	// half speed squared
	always_comb begin
		logic [W:0] s2;
		s2 = sm_add(sm_add(sq_s6[0], sq_s6[1]), sq_s6[2]);
		hs_s6 = {2'b00, s2[W-1:1]};
	end

	igsc_pipe #(.WIDTH(2 + 13 * SM), .DEPTH(1)) u_p4 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s6, fault_s6, a_s6, rr_s6, rho_s6, vel_s6, et_s6, hs_s6, cvt_s6}),
		.q({op_s7, fault_s7, a_s7, rr_s7, rho_s7, vel_s7, et_s7, hs_s7, cvt_s7})
	);

	// total energy, or internal energy ahead of the cv divide
	always_comb begin
		if (op_s7 == OP_PRIM_TO_CONS) begin
			etn_s7 = sm_add(cvt_s7, hs_s7);
		end else begin
			etn_s7 = sm_add(et_s7, {~hs_s7[W], hs_s7[W-1:0]});
		end
	end

	igsc_pipe #(.WIDTH(2 + 11 * SM), .DEPTH(1)) u_p5 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s7, fault_s7, a_s7, rr_s7, rho_s7, vel_s7,
			(op_s7 == OP_PRIM_TO_CONS) ? etn_s7 : et_s7}),
		.q({op_s8, fault_s8, a_s8, rr_s8, rho_s8, vel_s8, et_s8})
	);
	igsc_pipe #(.WIDTH(SM), .DEPTH(1)) u_p_etn (
		.clk(clk), .arst_n(arst_n), .en(en), .d(etn_s7), .q(etn_s8)
	);

	// temperature divide
	igsc_div #(.W(W), .F(F), .MW(MW)) u_div_t (
		.clk(clk), .en(en), .num(etn_s8), .den({1'b0, MW'(cv_q)}), .q(tq_s9)
	);

	igsc_pipe #(.WIDTH(2 + 11 * SM), .DEPTH(DL)) u_p6 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s8, fault_s8, a_s8, rr_s8, rho_s8, vel_s8, et_s8}),
		.q({op_s9, fault_s9, a_s9, rr_s9, rho_s9, vel_s9, et_s9})
	);

	// momenta, energy density and pressure
	assign prim_s9 = (op_s9 == OP_PRIM_TO_CONS);
	assign t_s9 = prim_s9 ? a_s9[1] : tq_s9;

	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_a (
		.clk(clk), .en(en),
		.a(prim_s9 ? ext(rho_s9) : ext(rr_s9)),
		.b(prim_s9 ? ext(vel_s9[0]) : ext(t_s9)),
		.p(m_s11[0])
	);
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_b (
		.clk(clk), .en(en), .a(ext(rho_s9)), .b(ext(vel_s9[1])), .p(m_s11[1])
	);
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_c (
		.clk(clk), .en(en), .a(ext(rho_s9)), .b(ext(vel_s9[2])), .p(m_s11[2])
	);
	igsc_mul #(.W(W), .F(F), .MW(MW)) u_mul_d (
		.clk(clk), .en(en), .a(ext(rho_s9)), .b(ext(et_s9)), .p(m_s11[3])
	);
	igsc_pipe #(.WIDTH(2 + 11 * SM), .DEPTH(2)) u_p7 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({op_s9, fault_s9, a_s9, rho_s9, vel_s9, et_s9, t_s9}),
		.q({op_s11, fault_s11, a_s11, rho_s11, vel_s11, et_s11, t_s11})
	);

	// output register
	assign prim_s11 = (op_s11 == OP_PRIM_TO_CONS);

	always_ff @(posedge clk) begin
		if (en) begin
			if (fault_s11) begin
				out_ch.density <= '0;
				out_ch.vel_x <= '0;
				out_ch.vel_y <= '0;
				out_ch.vel_z <= '0;
				out_ch.specific_energy <= '0;
				out_ch.temperature <= '0;
				out_ch.pressure <= '0;
				out_ch.mom_x <= '0;
				out_ch.mom_y <= '0;
				out_ch.mom_z <= '0;
				out_ch.energy_density <= '0;
				out_ch.div_fault <= 1'b1;
			end else begin
				out_ch.density <= to_raw(rho_s11);
				out_ch.vel_x <= to_raw(vel_s11[0]);
				out_ch.vel_y <= to_raw(vel_s11[1]);
				out_ch.vel_z <= to_raw(vel_s11[2]);
				out_ch.specific_energy <= to_raw(et_s11);
				out_ch.temperature <= to_raw(t_s11);
				out_ch.pressure <= to_raw(prim_s11 ? a_s11[0] : m_s11[0]);
				out_ch.mom_x <= to_raw(prim_s11 ? m_s11[0] : a_s11[1]);
				out_ch.mom_y <= to_raw(prim_s11 ? m_s11[1] : a_s11[2]);
				out_ch.mom_z <= to_raw(prim_s11 ? m_s11[2] : a_s11[3]);
				out_ch.energy_density <= to_raw(prim_s11 ? m_s11[3] : a_s11[4]);
				out_ch.div_fault <= 1'b0;
			end
		end
	end

	`IGSC_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_ch.valid && in_ch.ready, v_s1,
		"accepted transaction did not enter the pipeline")
	`IGSC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, $stable(v_s1),
		"pipeline moved during a stall")
	`IGSC_ASSERT(a_fault_zero, clk, arst_n,
		(out_ch.valid && out_ch.div_fault) |-> (out_ch.density == '0 &&
		out_ch.pressure == '0 && out_ch.energy_density == '0),
		"faulted result carries nonzero state")
endmodule
`default_nettype wire
